@@ hdl/cca_pkg.sv @@
// Shared types, widths, action codes and arithmetic helpers for the RGBA color ALU.
// Used by every module of the block; depends on nothing.
package cca_pkg;

    localparam int CH_W      = 8;                      // channel width
    localparam int FRAC_W    = 8;                      // scalar fraction bits
    localparam int SCALAR_W  = 16;
    localparam int NUM_W     = 17;                     // widest dividend (blend sum)
    localparam int DEN_W     = 16;                     // widest divisor (scalar)
    localparam int ACC_W     = NUM_W + NUM_W;          // {remainder, quotient}
    localparam int DIV_STAGES = NUM_W;                 // one quotient bit per stage
    localparam int LANES     = 4;
    localparam int PIPE_DEPTH = 1 + DIV_STAGES + 1;    // operand prep, divide, merge

    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [DEN_W-1:0] t_den;
    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [CH_W-1:0]  t_ch;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_MULC  = 3'd2,
        ACT_DIVC  = 3'd3,
        ACT_MULS  = 3'd4,
        ACT_DIVS  = 3'd5,
        ACT_BLEND = 3'd6,
        ACT_PASS  = 3'd7
    } t_action;

    typedef struct packed {
        logic [2:0]                 action;
        logic [CH_W-1:0]            a_red;
        logic [CH_W-1:0]            a_green;
        logic [CH_W-1:0]            a_blue;
        logic [CH_W-1:0]            a_alpha;
        logic [CH_W-1:0]            b_red;
        logic [CH_W-1:0]            b_green;
        logic [CH_W-1:0]            b_blue;
        logic [CH_W-1:0]            b_alpha;
        logic signed [SCALAR_W-1:0] scalar;
        logic [CH_W-1:0]            blend_alpha;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
        logic [15:0] packed_565;
    } t_out;

    // Per-lane operands; on a blend the alpha lane gives blend_alpha, or 0 if xa+ya=0.
    typedef struct packed {
        logic [2:0]                 action;
        logic [CH_W-1:0]            x;
        logic [CH_W-1:0]            y;
        logic [CH_W-1:0]            xa;
        logic [CH_W-1:0]            ya;
        logic signed [SCALAR_W-1:0] scalar;
        logic [CH_W-1:0]            blend_alpha;
        logic                       alpha_lane;
    } t_lane_in;

    // One restoring-division step on {remainder, dividend/quotient}.
    function automatic t_acc div_step(t_acc acc, t_den den);
        t_acc t;
        t_num up;
        t  = {acc[ACC_W-2:0], 1'b0};
        up = t[ACC_W-1:NUM_W];
        if (up >= t_num'(den)) begin
            up = up - t_num'(den);
            t[0] = 1'b1;
        end
        t[ACC_W-1:NUM_W] = up;
        return t;
    endfunction

    // Truncating v*m/255 for the 565 packing; exact for products below 65280.
    function automatic logic [5:0] scale_255(t_ch v, logic [5:0] m);
        logic [15:0] p;
        logic [15:0] q;
        p = 16'(v) * 16'(m);
        q = (p + 16'd1 + (p >> 8)) >> 8;
        return q[5:0];
    endfunction

endpackage

@@ hdl/cca_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cca_pkg for widths and the step function.
module cca_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  cca_pkg::t_num i_num,
    input  cca_pkg::t_den i_den,
    output cca_pkg::t_num o_quo
);

    cca_pkg::t_acc r_acc [cca_pkg::DIV_STAGES];
    cca_pkg::t_den r_den [cca_pkg::DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= cca_pkg::div_step({cca_pkg::t_num'(0), i_num}, i_den);
            r_den[0] <= i_den;
            for (int k = 1; k < cca_pkg::DIV_STAGES; k++) begin
                r_acc[k] <= cca_pkg::div_step(r_acc[k-1], r_den[k-1]);
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_acc[cca_pkg::DIV_STAGES-1][cca_pkg::NUM_W-1:0];

endmodule

@@ hdl/cca_lane.sv @@
// One color channel lane: operand prep register, pipelined divide, clamp.
// Depends on cca_pkg and cca_div.
module cca_lane (
    input  logic              i_clk,
    input  logic              i_en,
    input  cca_pkg::t_lane_in i_lane,
    output cca_pkg::t_ch      o_res
);

    cca_pkg::t_num r_num, n_num;
    cca_pkg::t_den r_den, n_den;
    cca_pkg::t_num quo;
    logic [cca_pkg::CH_W:0]     wsum;
    logic [2*cca_pkg::CH_W-1:0] prod_xy;
    logic [2*cca_pkg::CH_W-1:0] prod_xa;
    logic [2*cca_pkg::CH_W-1:0] prod_ya;
    logic [cca_pkg::CH_W+cca_pkg::SCALAR_W-2:0] prod_s;

    always_comb begin
        wsum    = {1'b0, i_lane.xa} + {1'b0, i_lane.ya};
        prod_xy = i_lane.x * i_lane.y;
        prod_xa = i_lane.x * i_lane.xa;
        prod_ya = i_lane.y * i_lane.ya;
        prod_s  = (cca_pkg::CH_W+cca_pkg::SCALAR_W-1)'(i_lane.x)
                  * (cca_pkg::CH_W+cca_pkg::SCALAR_W-1)'(i_lane.scalar[cca_pkg::SCALAR_W-2:0]);
        n_num = '0;
        n_den = cca_pkg::t_den'(1);
        case (cca_pkg::t_action'(i_lane.action))
            cca_pkg::ACT_ADD: begin
                n_num = cca_pkg::t_num'({1'b0, i_lane.x} + {1'b0, i_lane.y});
            end
            cca_pkg::ACT_SUB: begin
                n_num = (i_lane.x > i_lane.y) ? cca_pkg::t_num'(i_lane.x - i_lane.y) : '0;
            end
            cca_pkg::ACT_MULC: begin
                n_num = cca_pkg::t_num'(prod_xy);
                n_den = cca_pkg::t_den'(cca_pkg::CH_MAX);
            end
            cca_pkg::ACT_DIVC: begin
                n_num = cca_pkg::t_num'({i_lane.x, {cca_pkg::CH_W{1'b0}}})
                        - cca_pkg::t_num'(i_lane.x);
                n_den = cca_pkg::t_den'(i_lane.y);
            end
            cca_pkg::ACT_MULS: begin
                if (i_lane.scalar > 0)
                    n_num = cca_pkg::t_num'(prod_s >> cca_pkg::FRAC_W);
            end
            cca_pkg::ACT_DIVS: begin
                if (i_lane.scalar >= 0) begin
                    n_num = cca_pkg::t_num'({i_lane.x, {cca_pkg::FRAC_W{1'b0}}});
                    n_den = cca_pkg::t_den'(i_lane.scalar);
                end
            end
            cca_pkg::ACT_BLEND: begin
                if (i_lane.alpha_lane) begin
                    n_num = (wsum == '0) ? '0 : cca_pkg::t_num'(i_lane.blend_alpha);
                end else begin
                    n_num = cca_pkg::t_num'(prod_xa) + cca_pkg::t_num'(prod_ya);
                    n_den = cca_pkg::t_den'(wsum);
                end
            end
            default: begin
                n_num = cca_pkg::t_num'(i_lane.x);
            end
        endcase
        // zero divisor: full scale, or zero when the dividend is zero too
        if (n_den == '0) begin
            n_num = (n_num == '0) ? '0 : cca_pkg::t_num'(cca_pkg::CH_MAX);
            n_den = cca_pkg::t_den'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    cca_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (quo)
    );

    assign o_res = (quo > cca_pkg::t_num'(cca_pkg::CH_MAX)) ? cca_pkg::CH_MAX
                                                            : quo[cca_pkg::CH_W-1:0];

endmodule

@@ hdl/cca_merge.sv @@
// Merge stage: gathers the four lane results and adds the RGB565 packing.
// Depends on cca_pkg.
module cca_merge (
    input  logic          i_clk,
    input  logic          i_en,
    input  cca_pkg::t_ch  i_res [cca_pkg::LANES],
    output cca_pkg::t_out o_out
);

    cca_pkg::t_out r_out, n_out;
    logic [5:0]    red5;
    logic [5:0]    green6;
    logic [5:0]    blue5;

    always_comb begin
        red5   = cca_pkg::scale_255(i_res[0], 6'd31);
        green6 = cca_pkg::scale_255(i_res[1], 6'd63);
        blue5  = cca_pkg::scale_255(i_res[2], 6'd31);
        n_out.out_red    = 8'(i_res[0]);
        n_out.out_green  = 8'(i_res[1]);
        n_out.out_blue   = 8'(i_res[2]);
        n_out.out_alpha  = 8'(i_res[3]);
        n_out.packed_565 = {red5[4:0], green6, blue5[4:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

@@ hdl/rgba_color_alu.sv @@
// Top level of the RGBA color ALU: four channel lanes, merge stage, output skid.
// Depends on cca_pkg, cca_lane, cca_div and cca_merge.
//
// Usage: present an item (two colors, scalar, blend alpha, action) on i_in with
// i_valid; it is taken at an edge where i_valid and o_ready are both high.
// The result item appears on o_out with o_valid and is taken when i_ready is high.
// Path from acceptance to o_valid: the operand prep register loads at the
// accepting edge, then 17 divider stages, 1 merge, 1 output register.
// Throughput: one item per cycle while o_ready is high; the 17-stage restoring
// divider per lane is fully pipelined, one bit per stage; every action uses it.
// Reset (synchronous, active low) empties the pipeline and the output stage.
// Stall: when the receiver holds i_ready low, one more item lands in a skid
// register; while it is full, o_ready drops and the whole pipeline holds.
module rgba_color_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cca_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_ready,
    output cca_pkg::t_out o_out
);

    logic                 en;
    logic                 r_vld [cca_pkg::PIPE_DEPTH];
    cca_pkg::t_lane_in    lane_in [cca_pkg::LANES];
    cca_pkg::t_ch         lane_res [cca_pkg::LANES];
    cca_pkg::t_out        pipe_out;
    logic                 pipe_vld;
    logic                 r_ov;
    cca_pkg::t_out        r_od;
    logic                 r_sv;
    cca_pkg::t_out        r_sd;

    assign en      = !r_sv;
    assign o_ready = en;

    always_comb begin
        for (int i = 0; i < cca_pkg::LANES; i++) begin
            lane_in[i].action      = i_in.action;
            lane_in[i].xa          = i_in.a_alpha;
            lane_in[i].ya          = i_in.b_alpha;
            lane_in[i].scalar      = i_in.scalar;
            lane_in[i].blend_alpha = i_in.blend_alpha;
            lane_in[i].alpha_lane  = 1'b0;
        end
        lane_in[0].x = i_in.a_red;    lane_in[0].y = i_in.b_red;
        lane_in[1].x = i_in.a_green;  lane_in[1].y = i_in.b_green;
        lane_in[2].x = i_in.a_blue;   lane_in[2].y = i_in.b_blue;
        lane_in[3].x = i_in.a_alpha;  lane_in[3].y = i_in.b_alpha;
        lane_in[3].alpha_lane = 1'b1;
    end

    for (genvar g = 0; g < cca_pkg::LANES; g++) begin : g_lane
        cca_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (lane_in[g]),
            .o_res  (lane_res[g])
        );
    end

    cca_merge u_merge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_res (lane_res),
        .o_out (pipe_out)
    );

    // Valid bits march alongside the lane data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cca_pkg::PIPE_DEPTH; k++)
                r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < cca_pkg::PIPE_DEPTH; k++)
                r_vld[k] <= r_vld[k-1];
        end
    end

    assign pipe_vld = r_vld[cca_pkg::PIPE_DEPTH-1];

    // Output register with a one-item skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_ov && !i_ready) begin
            if (en && pipe_vld) begin
                r_sv <= 1'b1;
                r_sd <= pipe_out;
            end
        end else if (r_sv) begin
            r_ov <= 1'b1;
            r_od <= r_sd;
            r_sv <= 1'b0;
        end else begin
            r_ov <= pipe_vld;
            r_od <= pipe_out;
        end
    end

    assign o_valid = r_ov;
    assign o_out   = r_od;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds an item while output is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !i_ready))
        else $error("skid filled without a stalled output");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |=> r_ov)
        else $error("output lost after skid");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule
